@@ hdl/llnm_pkg.sv @@
package llnm_pkg;

    localparam int NODE_COUNT_DEF = 64;
    localparam int FIELD_W        = 6;
    localparam int UA_W           = 6;

    typedef enum logic [3:0] {
        REQ_ADD       = 4'd0,
        REQ_ADD_TAIL  = 4'd1,
        REQ_DEL       = 4'd2,
        REQ_DEL_INIT  = 4'd3,
        REQ_MOVE      = 4'd4,
        REQ_MOVE_TAIL = 4'd5,
        REQ_SPLICE    = 4'd6,
        REQ_DEQUEUE   = 4'd7,
        REQ_REPLACE   = 4'd8,
        REQ_REP_INIT  = 4'd9,
        REQ_IS_EMPTY  = 4'd10
    } t_req;

    typedef struct packed {
        logic [3:0]         req_type;
        logic [FIELD_W-1:0] node_a;
        logic [FIELD_W-1:0] node_b;
    } t_cmd;

    typedef struct packed {
        logic [FIELD_W-1:0] node_out;
        logic               found;
        logic               empty_res;
    } t_res;

    // operand select for pointer-table addresses and write data
    typedef enum logic [2:0] {
        SEL_A  = 3'd0,
        SEL_B  = 3'd1,
        SEL_P  = 3'd2,
        SEL_N  = 3'd3,
        SEL_RN = 3'd4,
        SEL_RP = 3'd5
    } t_sel;

    typedef enum logic [1:0] {
        RES_NONE  = 2'd0,
        RES_DEQ   = 2'd1,
        RES_EMPTY = 2'd2
    } t_res_sel;

    typedef struct packed {
        t_sel            rn_addr;
        t_sel            rp_addr;
        logic            wn_en;
        t_sel            wn_addr;
        t_sel            wn_data;
        logic            wp_en;
        t_sel            wp_addr;
        t_sel            wp_data;
        logic            ld_p;
        logic            ld_n;
        logic            jmp_eq;
        logic [UA_W-1:0] jmp_to;
        logic            done;
        t_res_sel        res;
    } t_uop;

    localparam t_uop UOP_NOP = '0;

    localparam logic [UA_W-1:0] UA_FIN  = 6'd0;
    localparam logic [UA_W-1:0] UA_ADD  = 6'd1;
    localparam logic [UA_W-1:0] UA_ADDT = 6'd4;
    localparam logic [UA_W-1:0] UA_DEL  = 6'd7;
    localparam logic [UA_W-1:0] UA_DELI = 6'd9;
    localparam logic [UA_W-1:0] UA_MOVE = 6'd12;
    localparam logic [UA_W-1:0] UA_MOVT = 6'd17;
    localparam logic [UA_W-1:0] UA_SPL  = 6'd22;
    localparam logic [UA_W-1:0] UA_DEQ  = 6'd25;
    localparam logic [UA_W-1:0] UA_REP  = 6'd29;
    localparam logic [UA_W-1:0] UA_REPI = 6'd32;
    localparam logic [UA_W-1:0] UA_EMP  = 6'd36;

    // v mod n by restoring subtraction, no divider
    function automatic logic [FIELD_W-1:0] node_mod(logic [FIELD_W-1:0] v, int n);
        int r;
        r = int'(v);
        for (int k = FIELD_W - 1; k >= 0; k--) begin
            if (r >= (n << k)) begin
                r = r - (n << k);
            end
        end
        return FIELD_W'(r);
    endfunction

    function automatic logic [UA_W-1:0] dispatch(t_req req);
        logic [UA_W-1:0] ua;
        case (req)
            REQ_ADD:       ua = UA_ADD;
            REQ_ADD_TAIL:  ua = UA_ADDT;
            REQ_DEL:       ua = UA_DEL;
            REQ_DEL_INIT:  ua = UA_DELI;
            REQ_MOVE:      ua = UA_MOVE;
            REQ_MOVE_TAIL: ua = UA_MOVT;
            REQ_SPLICE:    ua = UA_SPL;
            REQ_DEQUEUE:   ua = UA_DEQ;
            REQ_REPLACE:   ua = UA_REP;
            REQ_REP_INIT:  ua = UA_REPI;
            REQ_IS_EMPTY:  ua = UA_EMP;
            default:       ua = UA_FIN;
        endcase
        return ua;
    endfunction

    // microcode: reads land in RN/RP in the next step
    function automatic t_uop rom_word(logic [UA_W-1:0] ua);
        t_uop w;
        w = UOP_NOP;
        case (ua)
            // add
            6'd1: begin
                w.rn_addr = SEL_B;
            end
            6'd2: begin
                w.wp_en = 1'b1; w.wp_addr = SEL_RN; w.wp_data = SEL_A;
                w.wn_en = 1'b1; w.wn_addr = SEL_A;  w.wn_data = SEL_RN;
            end
            6'd3: begin
                w.wp_en = 1'b1; w.wp_addr = SEL_A; w.wp_data = SEL_B;
                w.wn_en = 1'b1; w.wn_addr = SEL_B; w.wn_data = SEL_A;
                w.done  = 1'b1;
            end
            // add_tail
            6'd4: begin
                w.rp_addr = SEL_B;
            end
            6'd5: begin
                w.wp_en = 1'b1; w.wp_addr = SEL_B; w.wp_data = SEL_A;
                w.wn_en = 1'b1; w.wn_addr = SEL_A; w.wn_data = SEL_B;
                w.ld_p  = 1'b1;
            end
            6'd6: begin
                w.wp_en = 1'b1; w.wp_addr = SEL_A; w.wp_data = SEL_P;
                w.wn_en = 1'b1; w.wn_addr = SEL_P; w.wn_data = SEL_A;
                w.done  = 1'b1;
            end
            // del
            6'd7: begin
                w.rn_addr = SEL_A; w.rp_addr = SEL_A;
            end
            6'd8: begin
                w.wp_en = 1'b1; w.wp_addr = SEL_RN; w.wp_data = SEL_RP;
                w.wn_en = 1'b1; w.wn_addr = SEL_RP; w.wn_data = SEL_RN;
                w.done  = 1'b1;
            end
            // del_init
            6'd9: begin
                w.rn_addr = SEL_A; w.rp_addr = SEL_A;
            end
            6'd10: begin
                w.wp_en = 1'b1; w.wp_addr = SEL_RN; w.wp_data = SEL_RP;
                w.wn_en = 1'b1; w.wn_addr = SEL_RP; w.wn_data = SEL_RN;
            end
            6'd11: begin
                w.wp_en = 1'b1; w.wp_addr = SEL_A; w.wp_data = SEL_A;
                w.wn_en = 1'b1; w.wn_addr = SEL_A; w.wn_data = SEL_A;
                w.done  = 1'b1;
            end
            // move
            6'd12: begin
                w.rn_addr = SEL_A; w.rp_addr = SEL_A;
            end
            6'd13: begin
                w.wp_en = 1'b1; w.wp_addr = SEL_RN; w.wp_data = SEL_RP;
                w.wn_en = 1'b1; w.wn_addr = SEL_RP; w.wn_data = SEL_RN;
            end
            6'd14: begin
                w.rn_addr = SEL_B;
            end
            6'd15: begin
                w.wp_en = 1'b1; w.wp_addr = SEL_RN; w.wp_data = SEL_A;
                w.wn_en = 1'b1; w.wn_addr = SEL_A;  w.wn_data = SEL_RN;
            end
            6'd16: begin
                w.wp_en = 1'b1; w.wp_addr = SEL_A; w.wp_data = SEL_B;
                w.wn_en = 1'b1; w.wn_addr = SEL_B; w.wn_data = SEL_A;
                w.done  = 1'b1;
            end
            // move_tail
            6'd17: begin
                w.rn_addr = SEL_A; w.rp_addr = SEL_A;
            end
            6'd18: begin
                w.wp_en = 1'b1; w.wp_addr = SEL_RN; w.wp_data = SEL_RP;
                w.wn_en = 1'b1; w.wn_addr = SEL_RP; w.wn_data = SEL_RN;
            end
            6'd19: begin
                w.rp_addr = SEL_B;
            end
            6'd20: begin
                w.wp_en = 1'b1; w.wp_addr = SEL_B; w.wp_data = SEL_A;
                w.wn_en = 1'b1; w.wn_addr = SEL_A; w.wn_data = SEL_B;
                w.ld_p  = 1'b1;
            end
            6'd21: begin
                w.wp_en = 1'b1; w.wp_addr = SEL_A; w.wp_data = SEL_P;
                w.wn_en = 1'b1; w.wn_addr = SEL_P; w.wn_data = SEL_A;
                w.done  = 1'b1;
            end
            // splice
            6'd22: begin
                w.rn_addr = SEL_B; w.rp_addr = SEL_A;
            end
            6'd23: begin
                w.wp_en = 1'b1; w.wp_addr = SEL_A; w.wp_data = SEL_B;
                w.wn_en = 1'b1; w.wn_addr = SEL_B; w.wn_data = SEL_A;
                w.ld_p  = 1'b1; w.ld_n = 1'b1;
            end
            6'd24: begin
                w.wn_en = 1'b1; w.wn_addr = SEL_P; w.wn_data = SEL_N;
                w.wp_en = 1'b1; w.wp_addr = SEL_N; w.wp_data = SEL_P;
                w.done  = 1'b1;
            end
            // dequeue
            6'd25: begin
                w.rn_addr = SEL_A;
            end
            6'd26: begin
                w.rn_addr = SEL_RN;
                w.ld_n    = 1'b1;
                w.jmp_eq  = 1'b1; w.jmp_to = UA_FIN;
            end
            6'd27: begin
                w.wp_en = 1'b1; w.wp_addr = SEL_RN; w.wp_data = SEL_A;
                w.wn_en = 1'b1; w.wn_addr = SEL_A;  w.wn_data = SEL_RN;
            end
            6'd28: begin
                w.wp_en = 1'b1; w.wp_addr = SEL_N; w.wp_data = SEL_N;
                w.wn_en = 1'b1; w.wn_addr = SEL_N; w.wn_data = SEL_N;
                w.done  = 1'b1; w.res = RES_DEQ;
            end
            // replace
            6'd29: begin
                w.rn_addr = SEL_B; w.rp_addr = SEL_B;
            end
            6'd30: begin
                w.wp_en = 1'b1; w.wp_addr = SEL_RN; w.wp_data = SEL_A;
                w.wn_en = 1'b1; w.wn_addr = SEL_A;  w.wn_data = SEL_RN;
                w.ld_p  = 1'b1;
            end
            6'd31: begin
                w.wp_en = 1'b1; w.wp_addr = SEL_A; w.wp_data = SEL_P;
                w.wn_en = 1'b1; w.wn_addr = SEL_P; w.wn_data = SEL_A;
                w.done  = 1'b1;
            end
            // replace_init
            6'd32: begin
                w.rn_addr = SEL_B; w.rp_addr = SEL_B;
            end
            6'd33: begin
                w.wp_en = 1'b1; w.wp_addr = SEL_RN; w.wp_data = SEL_A;
                w.wn_en = 1'b1; w.wn_addr = SEL_A;  w.wn_data = SEL_RN;
                w.ld_p  = 1'b1;
            end
            6'd34: begin
                w.wp_en = 1'b1; w.wp_addr = SEL_A; w.wp_data = SEL_P;
                w.wn_en = 1'b1; w.wn_addr = SEL_P; w.wn_data = SEL_A;
            end
            6'd35: begin
                w.wp_en = 1'b1; w.wp_addr = SEL_B; w.wp_data = SEL_B;
                w.wn_en = 1'b1; w.wn_addr = SEL_B; w.wn_data = SEL_B;
                w.done  = 1'b1;
            end
            // is_empty
            6'd36: begin
                w.rn_addr = SEL_B;
            end
            6'd37: begin
                w.done = 1'b1; w.res = RES_EMPTY;
            end
            default: begin
                w.done = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

@@ hdl/llnm_seq.sv @@
module llnm_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_go,
    input  llnm_pkg::t_req i_req,
    input  logic           i_eq,
    output logic           o_run,
    output llnm_pkg::t_uop o_uop
);
    import llnm_pkg::*;

    logic            r_run, n_run;
    logic [UA_W-1:0] r_pc, n_pc;
    t_uop            w_word;

    assign w_word = rom_word(r_pc);
    assign o_run  = r_run;
    assign o_uop  = r_run ? w_word : UOP_NOP;

    always_comb begin
        n_run = r_run;
        n_pc  = r_pc;
        if (i_go) begin
            n_run = 1'b1;
            n_pc  = dispatch(i_req);
        end else if (r_run) begin
            if (w_word.done) begin
                n_run = 1'b0;
            end else if (w_word.jmp_eq && i_eq) begin
                n_pc = w_word.jmp_to;
            end else begin
                n_pc = r_pc + UA_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_pc  <= UA_FIN;
        end else begin
            r_run <= n_run;
            r_pc  <= n_pc;
        end
    end

endmodule

@@ hdl/linked_list_node_manager.sv @@
// Node table manager for circular doubly linked rings.
// Command channel: drive a request on i_cmd and raise start; it is transferred
// at a clock edge where start is high and busy is low. Busy stays high from
// the transfer until the last microcode step of that request completes.
// Result channel: o_strobe is high for one cycle with o_res; the receiver
// must take it then, there is no backpressure. Every request, including
// unused codes, gives exactly one result.
// Result timing: the strobe is registered from the last step and comes in the
// cycle after it; busy falls in that same cycle, so the next request can be
// transferred while the result is shown. Each request runs as a sequence of
// microcode steps, since each pointer table has one write port and one
// registered read port; a dequeue on an empty list ends early.
// Reset: after i_rst_n, a clearing pass self-links every node, one entry per
// cycle for NODE_COUNT cycles, with busy held high.
module linked_list_node_manager #(
    parameter int NODE_COUNT = llnm_pkg::NODE_COUNT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  llnm_pkg::t_cmd i_cmd,
    output logic           busy,
    output logic           o_strobe,
    output llnm_pkg::t_res o_res
);
    import llnm_pkg::*;

    localparam int IW = $clog2(NODE_COUNT);

    logic [IW-1:0] next_mem [NODE_COUNT];
    logic [IW-1:0] prev_mem [NODE_COUNT];

    logic          r_clr;
    logic [IW-1:0] r_clr_idx;
    logic [IW-1:0] r_a, r_b, r_p, r_n;
    logic [IW-1:0] r_rn, r_rp;
    logic          r_strobe;
    t_res          r_res, n_res;

    logic          w_go, w_run, w_eq;
    t_uop          w_uop;
    logic          w_wn_en, w_wp_en;
    logic [IW-1:0] w_wn_addr, w_wn_data, w_wp_addr, w_wp_data;
    logic [IW-1:0] w_rn_addr, w_rp_addr;

    function automatic logic [IW-1:0] pick(t_sel s, logic [IW-1:0] a, logic [IW-1:0] b,
                                           logic [IW-1:0] p, logic [IW-1:0] n,
                                           logic [IW-1:0] rn, logic [IW-1:0] rp);
        logic [IW-1:0] v;
        case (s)
            SEL_A:   v = a;
            SEL_B:   v = b;
            SEL_P:   v = p;
            SEL_N:   v = n;
            SEL_RN:  v = rn;
            SEL_RP:  v = rp;
            default: v = a;
        endcase
        return v;
    endfunction

    assign busy = r_clr | w_run;
    assign w_go = start & ~busy;
    assign w_eq = (r_rn == r_a);

    llnm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_go),
        .i_req   (t_req'(i_cmd.req_type)),
        .i_eq    (w_eq),
        .o_run   (w_run),
        .o_uop   (w_uop)
    );

    always_comb begin
        w_rn_addr = pick(w_uop.rn_addr, r_a, r_b, r_p, r_n, r_rn, r_rp);
        w_rp_addr = pick(w_uop.rp_addr, r_a, r_b, r_p, r_n, r_rn, r_rp);
        if (r_clr) begin
            w_wn_en   = 1'b1;
            w_wp_en   = 1'b1;
            w_wn_addr = r_clr_idx;
            w_wn_data = r_clr_idx;
            w_wp_addr = r_clr_idx;
            w_wp_data = r_clr_idx;
        end else begin
            w_wn_en   = w_uop.wn_en;
            w_wp_en   = w_uop.wp_en;
            w_wn_addr = pick(w_uop.wn_addr, r_a, r_b, r_p, r_n, r_rn, r_rp);
            w_wn_data = pick(w_uop.wn_data, r_a, r_b, r_p, r_n, r_rn, r_rp);
            w_wp_addr = pick(w_uop.wp_addr, r_a, r_b, r_p, r_n, r_rn, r_rp);
            w_wp_data = pick(w_uop.wp_data, r_a, r_b, r_p, r_n, r_rn, r_rp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wn_en) begin
            next_mem[w_wn_addr] <= w_wn_data;
        end
        r_rn <= next_mem[w_rn_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_wp_en) begin
            prev_mem[w_wp_addr] <= w_wp_data;
        end
        r_rp <= prev_mem[w_rp_addr];
    end

    always_comb begin
        n_res = '0;
        case (w_uop.res)
            RES_DEQ: begin
                n_res.node_out = FIELD_W'(r_n);
                n_res.found    = 1'b1;
            end
            RES_EMPTY: begin
                n_res.empty_res = (r_rn == r_b);
            end
            default: begin
                n_res = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= 1'b1;
            r_clr_idx <= '0;
            r_strobe  <= 1'b0;
        end else begin
            if (r_clr) begin
                r_clr_idx <= r_clr_idx + IW'(1);
                if (r_clr_idx == IW'(NODE_COUNT - 1)) begin
                    r_clr <= 1'b0;
                end
            end
            r_strobe <= w_uop.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_a <= IW'(node_mod(i_cmd.node_a, NODE_COUNT));
            r_b <= IW'(node_mod(i_cmd.node_b, NODE_COUNT));
        end
        if (w_uop.ld_p) begin
            r_p <= r_rp;
        end
        if (w_uop.ld_n) begin
            r_n <= r_rn;
        end
        if (w_uop.done) begin
            r_res <= n_res;
        end
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

@@ dv/tb_linked_list_node_manager.sv @@
module tb_linked_list_node_manager;
    import llnm_pkg::*;

    localparam int NODES      = NODE_COUNT_DEF;
    localparam int HEAD_BASE  = 32;
    localparam int HEADS      = 8;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_TAIL = 16;
    localparam logic [3:0] REQ_CODE_MAX = 4'hF;

    typedef logic [FIELD_W-1:0] t_node;

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_cmd i_cmd;
    logic busy;
    logic o_strobe;
    t_res o_res;

    t_node nxt_tbl [NODES];
    t_node prv_tbl [NODES];
    bit    in_list [NODES];

    t_res  results_due[$];
    int    errors;
    int    burst_left;
    int    req_count [16];
    int    nodes_taken;
    int    empty_heads;

    linked_list_node_manager #(.NODE_COUNT(NODES)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic link_between(input t_node n, input t_node p, input t_node q);
        prv_tbl[q] = n;
        nxt_tbl[n] = q;
        prv_tbl[n] = p;
        nxt_tbl[p] = n;
    endtask

    task automatic join_nodes(input t_node p, input t_node q);
        prv_tbl[q] = p;
        nxt_tbl[p] = q;
    endtask

    task automatic self_link(input t_node n);
        nxt_tbl[n] = n;
        prv_tbl[n] = n;
    endtask

    // pointer writes in fixed order so aliased operands resolve deterministically
    task automatic apply_request(input t_cmd cmd, output t_res r);
        t_node a, b, first, last, at, nx, taken;
        a = t_node'(int'(cmd.node_a) % NODES);
        b = t_node'(int'(cmd.node_b) % NODES);
        r = '0;
        case (cmd.req_type)
            REQ_ADD:       link_between(a, b, nxt_tbl[b]);
            REQ_ADD_TAIL:  link_between(a, prv_tbl[b], b);
            REQ_DEL:       join_nodes(prv_tbl[a], nxt_tbl[a]);
            REQ_DEL_INIT: begin
                join_nodes(prv_tbl[a], nxt_tbl[a]);
                self_link(a);
            end
            REQ_MOVE: begin
                join_nodes(prv_tbl[a], nxt_tbl[a]);
                link_between(a, b, nxt_tbl[b]);
            end
            REQ_MOVE_TAIL: begin
                join_nodes(prv_tbl[a], nxt_tbl[a]);
                link_between(a, prv_tbl[b], b);
            end
            REQ_SPLICE: begin
                first = a;
                last  = prv_tbl[a];
                at    = nxt_tbl[b];
                prv_tbl[first] = b;
                nxt_tbl[b]     = first;
                nxt_tbl[last]  = at;
                prv_tbl[at]    = last;
            end
            REQ_DEQUEUE: begin
                nx = nxt_tbl[a];
                if (nx != a) begin
                    taken = nx;
                    nx = nxt_tbl[taken];
                    prv_tbl[nx] = a;
                    nxt_tbl[a]  = nx;
                    self_link(taken);
                    r.node_out = taken;
                    r.found    = 1'b1;
                end
            end
            REQ_REPLACE:   link_between(a, prv_tbl[b], nxt_tbl[b]);
            REQ_REP_INIT: begin
                link_between(a, prv_tbl[b], nxt_tbl[b]);
                self_link(b);
            end
            REQ_IS_EMPTY:  r.empty_res = (nxt_tbl[b] == b);
            default: ;
        endcase
    endtask

    task automatic send_req(input logic [3:0] req, input t_node a, input t_node b,
                            output t_res pred);
        t_cmd cmd;
        int   gap;
        cmd.req_type = req;
        cmd.node_a   = a;
        cmd.node_b   = b;
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else if ($urandom_range(0, 19) == 0) begin
            burst_left = $urandom_range(8, 40);
            gap = 0;
        end else begin
            gap = $urandom_range(0, 12);
        end
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= cmd;
        do @(posedge i_clk); while (busy);
        apply_request(cmd, pred);
        results_due.push_back(pred);
        req_count[req]++;
        if (pred.found) nodes_taken++;
        if (pred.empty_res) empty_heads++;
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic bit find_node(input bit linked, output t_node n);
        int idx;
        for (int k = 0; k < 2 * NODES; k++) begin
            idx = $urandom_range(0, NODES - 1);
            if ((idx < HEAD_BASE || idx >= HEAD_BASE + HEADS) && in_list[idx] == linked) begin
                n = t_node'(idx);
                return 1'b1;
            end
        end
        n = '0;
        return 1'b0;
    endfunction

    // one list operation on the head/element partition, or a ring build and splice
    task automatic send_list_op();
        t_node h, e, f;
        t_res  res;
        int    pick;
        int    extra;
        h = t_node'(HEAD_BASE + $urandom_range(0, HEADS - 1));
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            if (find_node(1'b0, e)) begin
                send_req(pick < 20 ? REQ_ADD : REQ_ADD_TAIL, e, h, res);
                in_list[e] = 1'b1;
            end else begin
                send_req(REQ_IS_EMPTY, e, h, res);
            end
        end else if (pick < 55) begin
            if (find_node(1'b1, e)) begin
                send_req(pick < 45 ? REQ_MOVE : REQ_MOVE_TAIL, e, h, res);
            end else begin
                send_req(REQ_DEQUEUE, h, e, res);
            end
        end else if (pick < 67) begin
            if (find_node(1'b1, e)) begin
                send_req(pick < 63 ? REQ_DEL_INIT : REQ_DEL, e, h, res);
                in_list[e] = 1'b0;
            end else begin
                send_req(REQ_IS_EMPTY, e, h, res);
            end
        end else if (pick < 79) begin
            send_req(REQ_DEQUEUE, h, t_node'($urandom_range(0, NODES - 1)), res);
            if (res.found) in_list[res.node_out] = 1'b0;
        end else if (pick < 87) begin
            send_req(REQ_IS_EMPTY, t_node'($urandom_range(0, NODES - 1)), h, res);
        end else if (pick < 95) begin
            if (find_node(1'b1, e) && find_node(1'b0, f)) begin
                send_req(pick < 91 ? REQ_REPLACE : REQ_REP_INIT, f, e, res);
                in_list[f] = 1'b1;
                in_list[e] = 1'b0;
            end else begin
                send_req(REQ_DEQUEUE, h, e, res);
            end
        end else begin
            // build a small ring on a free node, then splice it into a list
            if (find_node(1'b0, e)) begin
                in_list[e] = 1'b1;
                extra = $urandom_range(0, 3);
                for (int k = 0; k < extra; k++) begin
                    if (find_node(1'b0, f)) begin
                        send_req(REQ_ADD, f, e, res);
                        in_list[f] = 1'b1;
                    end
                end
                send_req(REQ_SPLICE, e, h, res);
            end else begin
                send_req(REQ_IS_EMPTY, e, h, res);
            end
        end
    endtask

    task automatic test_directed_requests();
        t_res res;
        send_req(REQ_IS_EMPTY,  6'd63, 6'd0,  res);
        send_req(REQ_DEQUEUE,   6'd63, 6'd0,  res);
        send_req(REQ_ADD,       6'd63, 6'd0,  res);
        send_req(REQ_ADD,       6'd1,  6'd0,  res);
        send_req(REQ_ADD_TAIL,  6'd2,  6'd0,  res);
        send_req(REQ_IS_EMPTY,  6'd0,  6'd0,  res);
        send_req(REQ_MOVE,      6'd63, 6'd62, res);
        send_req(REQ_MOVE_TAIL, 6'd1,  6'd62, res);
        send_req(REQ_DEL,       6'd2,  6'd0,  res);
        send_req(REQ_DEL_INIT,  6'd1,  6'd0,  res);
        send_req(REQ_REPLACE,   6'd5,  6'd63, res);
        send_req(REQ_REP_INIT,  6'd6,  6'd5,  res);
        send_req(REQ_ADD,       6'd11, 6'd10, res);
        send_req(REQ_ADD,       6'd12, 6'd10, res);
        send_req(REQ_SPLICE,    6'd10, 6'd0,  res);
        send_req(REQ_DEQUEUE,   6'd0,  6'd63, res);
        for (int code = int'(REQ_IS_EMPTY) + 1; code <= int'(REQ_CODE_MAX); code++) begin
            send_req(4'(code), 6'd63, 6'd63, res);
        end
        // aliased operands: add after itself, move after itself, splice into own ring
        send_req(REQ_ADD,       6'd0,  6'd0,  res);
        send_req(REQ_MOVE,      6'd6,  6'd6,  res);
        send_req(REQ_SPLICE,    6'd62, 6'd62, res);
        wait_for_results();
    endtask

    task automatic test_wellformed_lists(input int n_items);
        for (int i = 0; i < NODES; i++) begin
            in_list[i] = (nxt_tbl[i] != t_node'(i));
        end
        for (int k = 0; k < n_items; k++) begin
            send_list_op();
            if ($urandom_range(0, 99) == 0) wait_for_results();
        end
        wait_for_results();
    endtask

    task automatic test_mixed_noise(input int n_items);
        t_res res;
        for (int k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 1) == 0) begin
                send_req(4'($urandom_range(0, 15)), t_node'($urandom_range(0, NODES - 1)),
                         t_node'($urandom_range(0, NODES - 1)), res);
            end else begin
                send_list_op();
            end
        end
        wait_for_results();
    endtask

    always @(posedge i_clk) begin : check_results
        t_res want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (results_due.size() == 0) begin
                errors++;
                $display("%0t: result with none pending: expected nothing actual %h",
                         $time, o_res);
            end else begin
                want = results_due.pop_front();
                if (o_res.node_out !== want.node_out) begin
                    errors++;
                    $display("%0t: node_out expected %0d actual %0d",
                             $time, want.node_out, o_res.node_out);
                end
                if (o_res.found !== want.found) begin
                    errors++;
                    $display("%0t: found expected %0b actual %0b",
                             $time, want.found, o_res.found);
                end
                if (o_res.empty_res !== want.empty_res) begin
                    errors++;
                    $display("%0t: empty_res expected %0b actual %0b",
                             $time, want.empty_res, o_res.empty_res);
                end
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_rst_n && start && !busy) || o_strobe === 1'b1) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("linked_list_node_manager regression: fail");
        $finish;
    end

    initial begin
        int total;
        for (int i = 0; i < NODES; i++) begin
            nxt_tbl[i] = t_node'(i);
            prv_tbl[i] = t_node'(i);
        end
        errors      = 0;
        burst_left  = 0;
        nodes_taken = 0;
        empty_heads = 0;
        total       = 0;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_cmd   = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_requests();
        test_wellformed_lists(800);
        test_mixed_noise(200);

        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (results_due.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, results_due.size());
        end
        for (int i = 0; i < 16; i++) total += req_count[i];
        $display("Covered %0d requests, all 16 codes (add %0d, splice %0d, unused %0d).",
                 total, req_count[REQ_ADD], req_count[REQ_SPLICE], req_count[REQ_CODE_MAX]);
        $display("Dequeue took %0d nodes; emptiness test saw %0d empty heads; %0d mismatches.",
                 nodes_taken, empty_heads, errors);
        if (errors == 0) begin
            $display("linked_list_node_manager regression: pass");
        end else begin
            $display("linked_list_node_manager regression: fail");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/llnm_pkg.sv
hdl/llnm_seq.sv
hdl/linked_list_node_manager.sv
dv/tb_linked_list_node_manager.sv
